// ===== sv/smau_pkg.sv =====
package smau_pkg;

  localparam int MAX_DIM    = 8;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DIM_W      = 4;
  localparam int ELEM_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SCALE_W    = 16;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int ACC_W      = PROD_W + IDX_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int CMD_W      = 2;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_RUN    = 2'd2
  } cmd_e;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_NEG   = 3'd2,
    OP_MUL   = 3'd3,
    OP_SCALE = 3'd4,
    OP_TRANS = 3'd5,
    OP_CMP   = 3'd6
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS = 3'd0,
    CFG_A_COLS = 3'd1,
    CFG_B_ROWS = 3'd2,
    CFG_B_COLS = 3'd3,
    CFG_OP     = 3'd4,
    CFG_SCALE  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_ACC,
    ST_SAT,
    ST_WB
  } state_e;

  typedef struct packed {
    logic [DIM_W-1:0]          a_rows;
    logic [DIM_W-1:0]          a_cols;
    logic [DIM_W-1:0]          b_rows;
    logic [DIM_W-1:0]          b_cols;
    logic [OP_W-1:0]           operation;
    logic signed [SCALE_W-1:0] scale_factor;
  } cfg_t;

  typedef struct packed {
    cmd_e                     cmd;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] elem;
  } item_t;

  function automatic logic [IDX_W-1:0] dim_m1(input logic [DIM_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(v - DIM_W'(1));
    end
    return r;
  endfunction

  function automatic logic signed [ELEM_W-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [ELEM_W-1:0] r;
    hi = {{(ACC_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      r = hi[ELEM_W-1:0];
    end else if (v < lo) begin
      r = lo[ELEM_W-1:0];
    end else begin
      r = v[ELEM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/small_matrix_arithmetic_unit.sv =====
// Load words: accepted one per cycle unless in_stall_o is high, and written to the store
// via the front register and queue when the back end is idle. A run word is popped;
// add, subtract, negate and transpose take RD, EX, WB per element; scale RD, EX,
// ACC, SAT, WB; multiply RD, EX, ACC per product term, then SAT, WB; compare RD, EX
// per pair, then WB; a shape error word WB. Output stalls hold WB; runs do not overlap.
// Reset clears control state and loads the listed register values; stores are not cleared.
module small_matrix_arithmetic_unit
  import smau_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic [IDX_W-1:0]         row_index_i,
  input  logic [IDX_W-1:0]         col_index_i,
  input  logic signed [ELEM_W-1:0] elem_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ELEM_W-1:0] elem_out_o,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic                     shape_error_o,
  output logic                     is_equal_o,
  output logic                     last_o
);

  cfg_t  cfg_q, cfg_d;
  logic  q_full, q_push, q_valid, q_pop;
  item_t push_item, head_item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_A_ROWS: cfg_d.a_rows       = cfg_data_i[DIM_W-1:0];
        CFG_A_COLS: cfg_d.a_cols       = cfg_data_i[DIM_W-1:0];
        CFG_B_ROWS: cfg_d.b_rows       = cfg_data_i[DIM_W-1:0];
        CFG_B_COLS: cfg_d.b_cols       = cfg_data_i[DIM_W-1:0];
        CFG_OP:     cfg_d.operation    = cfg_data_i[OP_W-1:0];
        CFG_SCALE:  cfg_d.scale_factor = cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{a_rows: DIM_W'(1), a_cols: DIM_W'(1), b_rows: DIM_W'(1),
                 b_cols: DIM_W'(1), operation: OP_ADD, scale_factor: SCALE_W'(1)};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  smau_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .elem_in_i   (elem_in_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (push_item)
  );

  smau_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item),
    .pop_i   (q_pop)
  );

  smau_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_item_i      (head_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .elem_out_o    (elem_out_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .shape_error_o (shape_error_o),
    .is_equal_o    (is_equal_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && shape_error_o) |-> (last_o && !is_equal_o && elem_out_o == '0))
    else $error("shape error word malformed");

  a_eq_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_equal_o) |-> (last_o && !shape_error_o))
    else $error("compare word malformed");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && q_full) |=> $stable(push_item))
    else $error("queue entry lost");
`endif

endmodule

// ===== sv/smau_front.sv =====
module smau_front
  import smau_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic [IDX_W-1:0]         row_index_i,
  input  logic [IDX_W-1:0]         col_index_i,
  input  logic signed [ELEM_W-1:0] elem_in_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output item_t                    q_item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  keep;
  logic  accept;

  always_comb begin
    unique case (command_i) inside
      CMD_LOAD_A, CMD_LOAD_B, CMD_RUN: keep = 1'b1;
      default:                         keep = 1'b0;
    endcase
  end

  assign q_push_o   = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_item_o   = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d = keep;
      item_d  = '{cmd: cmd_e'(command_i), row: row_index_i, col: col_index_i,
                  elem: elem_in_i};
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

// ===== sv/smau_fifo.sv =====
module smau_fifo
  import smau_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + FIFO_PTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + FIFO_PTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (FIFO_PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (FIFO_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== sv/smau_back.sv =====
module smau_back
  import smau_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     q_valid_i,
  input  item_t                    q_item_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ELEM_W-1:0] elem_out_o,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic                     shape_error_o,
  output logic                     is_equal_o,
  output logic                     last_o
);

  logic signed [ELEM_W-1:0] mem_a [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] mem_b [MAX_DIM*MAX_DIM];

  state_e st_q, st_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ELEM_W-1:0] res_q, res_d;
  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;
  logic single_q, single_d, err_q, err_d, eq_q, eq_d;

  logic out_valid_q, out_valid_d;
  logic signed [ELEM_W-1:0] out_elem_q;
  logic [IDX_W-1:0] out_row_q, out_col_q;
  logic out_err_q, out_eq_q, out_last_q;

  logic [IDX_W-1:0] arm1, acm1, brm1, bcm1, orm1, ocm1;
  logic [ADDR_W-1:0] a_addr, b_addr, w_addr;
  logic shape_bad, at_end, last_w, out_free, rd_en, wr_a, wr_b, is_run;
  logic [IDX_W-1:0] i_nx, j_nx;

  assign arm1 = dim_m1(cfg_i.a_rows);
  assign acm1 = dim_m1(cfg_i.a_cols);
  assign brm1 = dim_m1(cfg_i.b_rows);
  assign bcm1 = dim_m1(cfg_i.b_cols);

  always_comb begin
    orm1 = arm1;
    ocm1 = acm1;
    if (cfg_i.operation == OP_MUL) begin
      ocm1 = bcm1;
    end else if (cfg_i.operation == OP_TRANS) begin
      orm1 = acm1;
      ocm1 = arm1;
    end
  end

  always_comb begin
    case (cfg_i.operation) inside
      OP_ADD, OP_SUB: shape_bad = (arm1 != brm1) || (acm1 != bcm1);
      OP_MUL:         shape_bad = (acm1 != brm1);
      OP_NEG, OP_SCALE, OP_TRANS, OP_CMP: shape_bad = 1'b0;
      default:        shape_bad = 1'b1;
    endcase
  end

  assign at_end = (i_q == orm1) && (j_q == ocm1);
  assign last_w = single_q || at_end;
  assign i_nx   = (j_q == ocm1) ? i_q + IDX_W'(1) : i_q;
  assign j_nx   = (j_q == ocm1) ? '0 : j_q + IDX_W'(1);
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_run   = q_valid_i && (q_item_i.cmd == CMD_RUN);

  always_comb begin
    a_addr = {i_q, j_q};
    b_addr = {i_q, j_q};
    if (cfg_i.operation == OP_TRANS) begin
      a_addr = {j_q, i_q};
    end else if (cfg_i.operation == OP_MUL) begin
      a_addr = {i_q, k_q};
      b_addr = {k_q, j_q};
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (is_run) begin
          st_d = (shape_bad && cfg_i.operation != OP_CMP) ? ST_WB : ST_RD;
        end
      end
      ST_RD: st_d = ST_EX;
      ST_EX: begin
        if (cfg_i.operation == OP_MUL || cfg_i.operation == OP_SCALE) begin
          st_d = ST_ACC;
        end else if (cfg_i.operation == OP_CMP && !at_end) begin
          st_d = ST_RD;
        end else begin
          st_d = ST_WB;
        end
      end
      ST_ACC: begin
        st_d = (cfg_i.operation == OP_MUL && k_q != acm1) ? ST_RD : ST_SAT;
      end
      ST_SAT: st_d = ST_WB;
      ST_WB: begin
        if (out_free) begin
          st_d = last_w ? ST_IDLE : ST_RD;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    i_d = i_q;  j_d = j_q;  k_d = k_q;
    acc_d = acc_q;  prod_d = prod_q;  res_d = res_q;
    single_d = single_q;  err_d = err_q;  eq_d = eq_q;
    q_pop_o = 1'b0;  wr_a = 1'b0;  wr_b = 1'b0;  rd_en = 1'b0;
    w_addr = {q_item_i.row, q_item_i.col};
    unique case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          wr_a = (q_item_i.cmd == CMD_LOAD_A);
          wr_b = (q_item_i.cmd == CMD_LOAD_B);
          if (is_run) begin
            i_d = '0;  j_d = '0;  k_d = '0;
            acc_d = '0;  res_d = '0;
            eq_d = (arm1 == brm1) && (acm1 == bcm1);
            single_d = (cfg_i.operation == OP_CMP) || shape_bad;
            err_d = shape_bad && (cfg_i.operation != OP_CMP);
          end
        end
      end
      ST_RD: rd_en = 1'b1;
      ST_EX: begin
        case (cfg_i.operation)
          OP_CMP: begin
            if (a_rd_q != b_rd_q) begin
              eq_d = 1'b0;
            end
            if (at_end) begin
              i_d = '0;
              j_d = '0;
            end else begin
              i_d = i_nx;
              j_d = j_nx;
            end
          end
          OP_MUL:   prod_d = a_rd_q * b_rd_q;
          OP_SCALE: prod_d = a_rd_q * cfg_i.scale_factor;
          OP_ADD:   res_d = sat(ACC_W'(a_rd_q) + ACC_W'(b_rd_q));
          OP_SUB:   res_d = sat(ACC_W'(a_rd_q) - ACC_W'(b_rd_q));
          OP_NEG:   res_d = sat(ACC_W'(0) - ACC_W'(a_rd_q));
          OP_TRANS: res_d = a_rd_q;
          default:  res_d = '0;
        endcase
      end
      ST_ACC: begin
        if (cfg_i.operation == OP_MUL) begin
          acc_d = acc_q + ACC_W'(prod_q);
          k_d   = k_q + IDX_W'(1);
        end else begin
          acc_d = ACC_W'(prod_q);
        end
      end
      ST_SAT: begin
        res_d = (cfg_i.operation == OP_MUL) ? sat(acc_q >>> FRAC_BITS) : sat(acc_q);
      end
      ST_WB: begin
        if (out_free && !last_w) begin
          i_d = i_nx;  j_d = j_nx;  k_d = '0;  acc_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (st_q == ST_WB && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;  j_q <= j_d;  k_q <= k_d;
    acc_q <= acc_d;  prod_q <= prod_d;  res_q <= res_d;
    single_q <= single_d;  err_q <= err_d;  eq_q <= eq_d;
    if (st_q == ST_WB && out_free) begin
      out_elem_q <= res_q;
      out_row_q  <= i_q;
      out_col_q  <= j_q;
      out_err_q  <= err_q;
      out_eq_q   <= single_q && !err_q && eq_q;
      out_last_q <= last_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[w_addr] <= q_item_i.elem;
    end
    if (rd_en) begin
      a_rd_q <= mem_a[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[w_addr] <= q_item_i.elem;
    end
    if (rd_en) begin
      b_rd_q <= mem_b[b_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign elem_out_o    = out_elem_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign shape_error_o = out_err_q;
  assign is_equal_o    = out_eq_q;
  assign last_o        = out_last_q;

endmodule

// ===== dv/small_matrix_arithmetic_unit_test.sv =====
`timescale 1ns / 100ps

module small_matrix_arithmetic_unit_test;
  import smau_pkg::*;

  localparam logic [OP_W-1:0]  OP_SPARE  = 3'd7;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] elem;
  } word_t;

  typedef struct {
    logic signed [ELEM_W-1:0] elem;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     shape_error;
    logic                     is_equal;
    logic                     last;
  } result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [CMD_W-1:0]         command_i = '0;
  logic [IDX_W-1:0]         row_index_i = '0;
  logic [IDX_W-1:0]         col_index_i = '0;
  logic signed [ELEM_W-1:0] elem_in_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [ELEM_W-1:0] elem_out_o;
  logic [IDX_W-1:0]         out_row_o;
  logic [IDX_W-1:0]         out_col_o;
  logic                     shape_error_o;
  logic                     is_equal_o;
  logic                     last_o;

  small_matrix_arithmetic_unit uut (.*);

  always #1 clk_i = ~clk_i;

  word_t   pending_words[$];
  result_t expected_elems[$];
  int      mismatches = 0;
  int      words_sent = 0;
  bit      steady = 1'b0;
  bit      held_once = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  logic signed [ELEM_W-1:0] mat_a[MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] mat_b[MAX_DIM*MAX_DIM];
  logic [DIM_W-1:0]         m_a_rows = 4'd1, m_a_cols = 4'd1, m_b_rows = 4'd1, m_b_cols = 4'd1;
  logic [OP_W-1:0]          m_op = OP_ADD;
  logic signed [SCALE_W-1:0] m_scale = 16'sd1;

  function automatic int span(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic signed [ELEM_W-1:0] clip(logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = 128'sh7fff_ffff;
    lo = -hi - 1;
    if (v > hi) return hi[ELEM_W-1:0];
    if (v < lo) return lo[ELEM_W-1:0];
    return v[ELEM_W-1:0];
  endfunction

  task automatic add_result(logic signed [ELEM_W-1:0] v, int r, int c, bit se, bit eq,
                            bit lst);
    result_t e;
    e.elem = v;
    e.row = IDX_W'(r);
    e.col = IDX_W'(c);
    e.shape_error = se;
    e.is_equal = eq;
    e.last = lst;
    expected_elems.push_back(e);
  endtask

  task automatic predict_matrix(word_t w);
    int ar, ac, br, bc, orows, ocols;
    bit same;
    logic signed [127:0] x, y, acc;
    logic signed [ELEM_W-1:0] v;
    ar = span(m_a_rows);
    ac = span(m_a_cols);
    br = span(m_b_rows);
    bc = span(m_b_cols);
    if (w.cmd == CMD_LOAD_A) begin
      mat_a[w.row*MAX_DIM+w.col] = w.elem;
      return;
    end
    if (w.cmd == CMD_LOAD_B) begin
      mat_b[w.row*MAX_DIM+w.col] = w.elem;
      return;
    end
    if (w.cmd != CMD_RUN) return;
    if (m_op == OP_CMP) begin
      same = (ar == br) && (ac == bc);
      for (int i = 0; same && i < ar; i++)
        for (int j = 0; j < ac; j++)
          if (mat_a[i*MAX_DIM+j] != mat_b[i*MAX_DIM+j]) same = 1'b0;
      add_result('0, 0, 0, 1'b0, same, 1'b1);
      return;
    end
    if (m_op == OP_SPARE || ((m_op == OP_ADD || m_op == OP_SUB) && (ar != br || ac != bc))
        || (m_op == OP_MUL && ac != br)) begin
      add_result('0, 0, 0, 1'b1, 1'b0, 1'b1);
      return;
    end
    orows = ar;
    ocols = (m_op == OP_MUL) ? bc : ac;
    if (m_op == OP_TRANS) begin
      orows = ac;
      ocols = ar;
    end
    for (int i = 0; i < orows; i++) begin
      for (int j = 0; j < ocols; j++) begin
        x = mat_a[i*MAX_DIM+j];
        y = mat_b[i*MAX_DIM+j];
        case (m_op)
          OP_ADD: v = clip(x + y);
          OP_SUB: v = clip(x - y);
          OP_NEG: v = clip(-x);
          OP_MUL: begin
            acc = '0;
            for (int k = 0; k < ac; k++) begin
              x = mat_a[i*MAX_DIM+k];
              y = mat_b[k*MAX_DIM+j];
              acc = acc + x * y;
            end
            v = clip(acc >>> FRAC_BITS);
          end
          OP_SCALE: begin
            y = m_scale;
            v = clip(x * y);
          end
          default: v = mat_a[j*MAX_DIM+i];
        endcase
        add_result(v, i, j, 1'b0, 1'b0, (i + 1 == orows) && (j + 1 == ocols));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        w.cmd = command_i;
        w.row = row_index_i;
        w.col = col_index_i;
        w.elem = elem_in_i;
        predict_matrix(w);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
          w = pending_words.pop_front();
          in_valid_i <= 1'b1;
          command_i <= w.cmd;
          row_index_i <= w.row;
          col_index_i <= w.col;
          elem_in_i <= w.elem;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_elems.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: elem %h", elem_out_o);
        end else begin
          e = expected_elems.pop_front();
          if (elem_out_o !== e.elem || out_row_o !== e.row || out_col_o !== e.col ||
              shape_error_o !== e.shape_error || is_equal_o !== e.is_equal ||
              last_o !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h r%0d c%0d se%b eq%b l%b, got %h r%0d c%0d se%b eq%b l%b",
                       e.elem, e.row, e.col, e.shape_error, e.is_equal, e.last, elem_out_o,
                       out_row_o, out_col_o, shape_error_o, is_equal_o, last_o);
          end
        end
      end
      if (!held_once && expected_elems.size() > 40 && pending_words.size() > 8) begin
        held_once <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < 19);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[small_matrix_arithmetic_unit] ERROR");
      $finish;
    end
  end

  task automatic push_word(logic [CMD_W-1:0] cmd, int r, int c, logic signed [ELEM_W-1:0] v);
    word_t w;
    w.cmd = cmd;
    w.row = IDX_W'(r);
    w.col = IDX_W'(c);
    w.elem = v;
    pending_words.push_back(w);
    words_sent++;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || expected_elems.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
  endtask

  task automatic configure(int ar, int ac, int br, int bc, logic [OP_W-1:0] op,
                           logic signed [SCALE_W-1:0] sc);
    drain();
    write_reg(CFG_A_ROWS, CFG_DATA_W'(ar));
    write_reg(CFG_A_COLS, CFG_DATA_W'(ac));
    write_reg(CFG_B_ROWS, CFG_DATA_W'(br));
    write_reg(CFG_B_COLS, CFG_DATA_W'(bc));
    write_reg(CFG_OP, CFG_DATA_W'(op));
    write_reg(CFG_SCALE, sc);
    cfg_we_i <= 1'b0;
    m_a_rows = DIM_W'(ar);
    m_a_cols = DIM_W'(ac);
    m_b_rows = DIM_W'(br);
    m_b_cols = DIM_W'(bc);
    m_op = op;
    m_scale = sc;
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2, 3, 4: return $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(19))
      0: return 0;
      1: return $urandom_range(9, 15);
      2, 3: return MAX_DIM;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  initial begin
    int ar, ac, br, bc, op, n;
    logic signed [SCALE_W-1:0] sc;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < MAX_DIM; i++)
      for (int j = 0; j < MAX_DIM; j++) begin
        push_word(CMD_LOAD_A, i, j, pick_value());
        push_word(CMD_LOAD_B, i, j, pick_value());
      end

    configure(1, 1, 1, 1, OP_ADD, 16'sd1);
    push_word(CMD_LOAD_A, 0, 0, 32'sh7fff_ffff);
    push_word(CMD_LOAD_B, 0, 0, 32'sh7fff_ffff);
    push_word(CMD_RUN, 0, 0, '0);
    push_word(CMD_SPARE, 7, 7, 32'sh8000_0000);
    configure(1, 1, 1, 1, OP_SUB, 16'sd1);
    push_word(CMD_LOAD_B, 0, 0, 32'sh8000_0000);
    push_word(CMD_RUN, 0, 0, '0);
    configure(2, 1, 1, 1, OP_SUB, 16'sd1);
    push_word(CMD_RUN, 0, 0, '0);
    configure(1, 1, 1, 1, OP_NEG, 16'sd1);
    push_word(CMD_LOAD_A, 0, 0, 32'sh8000_0000);
    push_word(CMD_RUN, 0, 0, '0);
    configure(0, 15, 1, 1, OP_SCALE, -16'sd32768);
    push_word(CMD_RUN, 0, 0, '0);
    configure(2, 3, 2, 2, OP_MUL, 16'sd32767);
    push_word(CMD_RUN, 0, 0, '0);
    configure(8, 8, 8, 8, OP_MUL, 16'sd1);
    push_word(CMD_RUN, 0, 0, '0);
    configure(3, 2, 1, 1, OP_TRANS, 16'sd1);
    push_word(CMD_RUN, 0, 0, '0);
    configure(1, 1, 1, 1, OP_CMP, 16'sd1);
    push_word(CMD_LOAD_A, 0, 0, 32'sh0001_0000);
    push_word(CMD_LOAD_B, 0, 0, 32'sh0001_0000);
    push_word(CMD_RUN, 0, 0, '0);
    push_word(CMD_LOAD_B, 0, 0, 32'sh0001_0001);
    push_word(CMD_RUN, 0, 0, '0);
    configure(2, 2, 2, 2, OP_SPARE, 16'sd1);
    push_word(CMD_RUN, 0, 0, '0);

    configure(8, 8, 8, 8, OP_ADD, 16'sd1);
    push_word(CMD_RUN, 0, 0, '0);
    for (int k = 0; k < 20; k++)
      push_word(CMD_LOAD_A, $urandom_range(7), $urandom_range(7), pick_value());
    push_word(CMD_RUN, 0, 0, '0);

    n = 0;
    while (words_sent < 370) begin
      n++;
      steady = (n >= 4 && n < 8);
      op = ($urandom_range(15) == 0) ? OP_SPARE : $urandom_range(0, 6);
      ar = pick_dim();
      ac = pick_dim();
      br = pick_dim();
      bc = pick_dim();
      if ((op == OP_ADD || op == OP_SUB || op == OP_CMP) && $urandom_range(9) < 7) begin
        br = ar;
        bc = ac;
      end
      if (op == OP_MUL && $urandom_range(9) < 8) br = ac;
      case ($urandom_range(5))
        0: sc = 16'sh7fff;
        1: sc = 16'sh8000;
        default: sc = $urandom;
      endcase
      configure(ar, ac, br, bc, OP_W'(op), sc);
      for (int r = 0; r < 1 + $urandom_range(1); r++) begin
        for (int k = 0; k < $urandom_range(3, 15); k++) begin
          if ($urandom_range(19) == 0)
            push_word(CMD_SPARE, $urandom_range(7), $urandom_range(7), $urandom);
          else if (op == OP_CMP && $urandom_range(1) == 0) begin
            ar = $urandom_range(7);
            ac = $urandom_range(7);
            push_word(CMD_LOAD_B, ar, ac, mat_a[ar*MAX_DIM+ac]);
          end else
            push_word(CMD_LOAD_A + CMD_W'($urandom_range(1)), $urandom_range(7),
                      $urandom_range(7), pick_value());
        end
        push_word(CMD_RUN, $urandom_range(7), $urandom_range(7), $urandom);
      end
    end
    steady = 1'b0;

    drain();
    if (mismatches == 0) begin
      $display("[small_matrix_arithmetic_unit] OK");
    end else begin
      $display("[small_matrix_arithmetic_unit] ERROR");
    end
    $finish;
  end

endmodule
